>>> rtl/protobuf_field_encoder_top_defines.svh
// Assertion macros for the protobuf field encoder.
// Both sample on clk; the first is switched off while rst_n is low.
`ifndef PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH
`define PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH

`define PFE_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfe assertion failed");

`define PFE_CHECK_NR(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pfe reset assertion failed");

`endif

>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, codes and helper functions shared by the protobuf field encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

  typedef enum logic [1:0] {
    REQ_VARINT  = 2'd0,
    REQ_LEN_HDR = 2'd1,
    REQ_RAW     = 2'd2,
    REQ_BARE    = 2'd3
  } req_type_t;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [7:0] CONT_BIT    = 8'h80;
  localparam logic [7:0] LOW_MASK    = 8'h7F;

  // one classified item, handed from front to back
  typedef struct packed {
    logic        has_tag;
    logic        raw;
    logic [31:0] tag;
    logic [2:0]  tag_cnt;
    logic [63:0] value;
    logic [3:0]  val_cnt;
  } cmd_t;

  // bytes needed by a 64-bit varint (1..10)
  function automatic logic [3:0] varint_len(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if ((v >> (7 * i)) != 64'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // bytes needed by a 32-bit tag varint (1..5)
  function automatic logic [2:0] tag_len(input logic [31:0] t);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 1; i < 5; i++) begin
      if ((t >> (7 * i)) != 32'd0) n = 3'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> rtl/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if
// Request channel: valid/ready with one encode request per beat.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [28:0] field_number;
  logic [63:0] value;
  logic [7:0]  payload_byte;

  modport source (output valid, req_type, field_number, value, payload_byte,
                  input ready);
  modport sink   (input valid, req_type, field_number, value, payload_byte,
                  output ready);
endinterface

>>> rtl/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if
// Byte channel: valid/ready with one wire-format byte per beat.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

>>> rtl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Classifies each request: builds the tag and counts tag and value bytes.
// ----------------------------------------------------------------------------
module pfe_front (
  pfe_in_if.sink       in_ch,
  input  logic         q_ready,
  output logic         q_push,
  output pfe_pkg::cmd_t q_cmd
);
  import pfe_pkg::*;

  logic [2:0]  wire_type;
  logic [31:0] tag;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  always_comb begin
    wire_type = WIRE_VARINT;
    q_cmd.has_tag = 1'b0;
    q_cmd.raw     = 1'b0;
    q_cmd.value   = in_ch.value;
    case (req_type_t'(in_ch.req_type))
      REQ_VARINT: begin
        q_cmd.has_tag = 1'b1;
      end
      REQ_LEN_HDR: begin
        q_cmd.has_tag = 1'b1;
        wire_type     = WIRE_LEN;
      end
      REQ_RAW: begin
        q_cmd.raw   = 1'b1;
        q_cmd.value = {56'd0, in_ch.payload_byte};
      end
      REQ_BARE: begin
        q_cmd.has_tag = 1'b0;
      end
      default: begin
        q_cmd.has_tag = 1'b0;
      end
    endcase
    tag           = {in_ch.field_number, wire_type};
    q_cmd.tag     = tag;
    q_cmd.tag_cnt = tag_len(tag);
    q_cmd.val_cnt = varint_len(in_ch.value);
  end

endmodule

>>> rtl/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pfe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfe_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          head_valid,
  output pfe_pkg::cmd_t head_cmd
);
  import pfe_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Serialises one classified item into tag and value varint bytes or a raw payload byte.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  pfe_pkg::cmd_t q_cmd,
  output logic          q_pop,
  pfe_out_if.source     out_ch
);
  import pfe_pkg::*;
  `include "protobuf_field_encoder_top_defines.svh"

  logic        cur_valid_r, cur_valid_nxt;
  logic        phase_tag_r, phase_tag_nxt;
  logic        raw_r, raw_nxt;
  logic [31:0] tag_sh_r, tag_sh_nxt;
  logic [2:0]  tag_cnt_r, tag_cnt_nxt;
  logic [63:0] val_sh_r, val_sh_nxt;
  logic [3:0]  val_cnt_r, val_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic        emit;
  logic        cur_done;
  logic [7:0]  b_byte;
  logic        b_last;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = cur_valid_r && out_free;
  assign cur_done = emit && b_last;
  assign q_pop    = q_valid && (!cur_valid_r || cur_done);

  // byte chosen from the working item
  always_comb begin
    if (phase_tag_r) begin
      b_byte = (tag_cnt_r != 3'd1) ? (CONT_BIT | {1'b0, tag_sh_r[6:0]})
                                   : {1'b0, tag_sh_r[6:0]};
      b_last = 1'b0;
    end else if (raw_r) begin
      b_byte = val_sh_r[7:0];
      b_last = 1'b1;
    end else begin
      b_byte = (val_cnt_r != 4'd1) ? (CONT_BIT | (LOW_MASK & val_sh_r[7:0]))
                                   : (LOW_MASK & val_sh_r[7:0]);
      b_last = (val_cnt_r == 4'd1);
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    phase_tag_nxt = phase_tag_r;
    raw_nxt       = raw_r;
    tag_sh_nxt    = tag_sh_r;
    tag_cnt_nxt   = tag_cnt_r;
    val_sh_nxt    = val_sh_r;
    val_cnt_nxt   = val_cnt_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      phase_tag_nxt = q_cmd.has_tag;
      raw_nxt       = q_cmd.raw;
      tag_sh_nxt    = q_cmd.tag;
      tag_cnt_nxt   = q_cmd.tag_cnt;
      val_sh_nxt    = q_cmd.value;
      val_cnt_nxt   = q_cmd.val_cnt;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      if (phase_tag_r) begin
        tag_sh_nxt  = {7'd0, tag_sh_r[31:7]};
        tag_cnt_nxt = tag_cnt_r - 3'd1;
        if (tag_cnt_r == 3'd1) phase_tag_nxt = 1'b0;
      end else begin
        val_sh_nxt  = {7'd0, val_sh_r[63:7]};
        val_cnt_nxt = val_cnt_r - 4'd1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = b_byte;
      out_last_nxt  = b_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_tag_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_tag_r <= phase_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    tag_sh_r   <= tag_sh_nxt;
    tag_cnt_r  <= tag_cnt_nxt;
    val_sh_r   <= val_sh_nxt;
    val_cnt_r  <= val_cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  `PFE_CHECK(a_tag_phase_live, phase_tag_r |-> (cur_valid_r && tag_cnt_r != 3'd0))
  `PFE_CHECK(a_last_not_tag, (emit && b_last) |-> !phase_tag_r)
  `PFE_CHECK(a_val_cnt_live, (cur_valid_r && !phase_tag_r && !raw_r) |-> val_cnt_r != 4'd0)
  `PFE_CHECK_NR(a_reset_idle, !rst_n |=> (!cur_valid_r && !out_valid_r && !phase_tag_r))

endmodule

>>> rtl/protobuf_field_encoder_top.sv
// An item's first byte reaches out_ch via the queue, working and output registers.
// Throughput: one byte per cycle while out_ch is ready; an item is 1 to 15 bytes
//   (tag bytes plus value bytes), sent by the single byte serialiser.
// Raw payload items therefore sustain one item per cycle while out_ch is ready.
// Reset: synchronous active-low rst_n empties the queue, the serialiser and
//   the output register.
// ----------------------------------------------------------------------------
// protobuf_field_encoder_top
// Protocol buffer wire-format field encoder: classifier, queue, serialiser.
// ----------------------------------------------------------------------------
module protobuf_field_encoder_top (
  input  logic      clk,
  input  logic      rst_n,
  pfe_in_if.sink    in_ch,
  pfe_out_if.source out_ch
);
  import pfe_pkg::*;

  logic q_ready;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  pfe_front u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  pfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (head_valid),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the protobuf field encoder. Each accepted request
// is expanded into the wire bytes it should produce. Every output beat is
// compared with the oldest of those bytes. Covers corner values and packed
// or string bodies, then random traffic with random gaps on both channels
// and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import pfe_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  protobuf_field_encoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wire_byte_t wire_bytes_q[$];
  int         mismatch_count = 0;
  bit         gaps_on        = 1'b1;
  bit         stalls_on      = 1'b1;
  bit         hold_req       = 1'b0;
  bit         hold_taken     = 1'b0;
  int         hold_left      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_wire_byte(input logic [7:0] data_b, input bit last_b);
    wire_byte_t wb;
    wb.data      = data_b;
    wb.last      = last_b;
    wire_bytes_q = {wire_bytes_q, wb};
  endfunction

  // base-128 groups, least significant first
  function automatic void push_varint(input logic [63:0] v, input bit ends_item);
    logic [63:0] rest;
    logic [7:0]  b;
    rest = v;
    do begin
      b    = rest[7:0] & LOW_MASK;
      rest = rest >> 7;
      if (rest != 64'd0) b = b | CONT_BIT;
      queue_wire_byte(b, ends_item && (rest == 64'd0));
    end while (rest != 64'd0);
  endfunction

  function automatic void predict_wire_bytes(input req_type_t kind, input logic [28:0] fnum,
                                             input logic [63:0] val, input logic [7:0] pbyte);
    case (kind)
      REQ_VARINT: begin
        push_varint(64'({fnum, WIRE_VARINT}), 1'b0);
        push_varint(val, 1'b1);
      end
      REQ_LEN_HDR: begin
        push_varint(64'({fnum, WIRE_LEN}), 1'b0);
        push_varint(val, 1'b1);
      end
      REQ_RAW: begin
        queue_wire_byte(pbyte, 1'b1);
      end
      default: begin
        push_varint(val, 1'b1);
      end
    endcase
  endfunction

  // random bit length so every varint size turns up
  function automatic logic [63:0] rand_varint_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [28:0] rand_field_number();
    return 29'($urandom) >> $urandom_range(0, 28);
  endfunction

  task automatic send_item(input req_type_t kind, input logic [28:0] fnum,
                           input logic [63:0] val, input logic [7:0] pbyte);
    if (gaps_on && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= kind;
    in_ch.field_number <= fnum;
    in_ch.value        <= val;
    in_ch.payload_byte <= pbyte;
    do @(posedge clk); while (!in_ch.ready);
    predict_wire_bytes(kind, fnum, val, pbyte);
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (wire_bytes_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_bytes
    wire_byte_t exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (wire_bytes_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                  out_ch.out_byte, out_ch.last_byte));
      end else begin
        exp_b = wire_bytes_q.pop_front();
        if (out_ch.out_byte !== exp_b.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_ch.out_byte, exp_b.data));
        if (out_ch.last_byte !== exp_b.last)
          report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                    out_ch.last_byte, exp_b.last, exp_b.data));
      end
    end
  end

  // byte sink: random stalls, or a forced hold-off while hold_left counts down
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (stalls_on && $urandom_range(99) < 17) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic test_corner_values();
    send_item(REQ_VARINT, 29'd0, 64'd0, 8'h00);                 // field zero, zero value
    send_item(REQ_VARINT, '1, '1, 8'hA5);                       // longest run
    send_item(REQ_VARINT, 29'd1, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00); // negative int
    send_item(REQ_VARINT, 29'd15, 64'd127, 8'h00);
    send_item(REQ_VARINT, 29'd16, 64'd128, 8'h00);
    send_item(REQ_VARINT, 29'd150, 64'd1, 8'h00);               // bool
    send_item(REQ_VARINT, 29'h1000_0000, 64'h8000_0000_0000_0000, 8'h00);
    send_item(REQ_LEN_HDR, 29'd0, 64'd0, 8'h00);
    send_item(REQ_LEN_HDR, '1, 64'd300, 8'hFF);
    send_item(REQ_LEN_HDR, 29'd2, 64'h8000_0000_0000_0000, 8'h00);
    send_item(REQ_RAW, 29'd0, 64'd0, 8'h00);
    send_item(REQ_RAW, '1, '1, 8'hFF);                          // field and value unused
    send_item(REQ_RAW, 29'd5, 64'd99, 8'h5A);
    send_item(REQ_BARE, 29'd0, 64'd0, 8'h00);
    send_item(REQ_BARE, '1, 64'd127, 8'hFF);                    // field and byte unused
    send_item(REQ_BARE, 29'd0, 64'd128, 8'h00);
    send_item(REQ_BARE, 29'd0, '1, 8'h00);
    send_item(REQ_BARE, 29'd0, 64'h0100_0000_0000_0000, 8'h00);
    wait_for_drain();
  endtask

  // packed lists and strings: header with the body length, then the body
  task automatic test_length_bodies();
    logic [63:0] elems[$];
    logic [63:0] rest;
    logic [63:0] body_len;
    int          n_elems;
    for (int l = 0; l < 6; l++) begin
      elems    = {};
      body_len = 64'd0;
      n_elems  = $urandom_range(1, 8);
      if (l % 2 == 0) begin
        for (int e = 0; e < n_elems; e++) begin
          elems = {elems, rand_varint_value()};
          rest  = elems[e] >> 7;
          body_len++;
          while (rest != 64'd0) begin
            body_len++;
            rest = rest >> 7;
          end
        end
        send_item(REQ_LEN_HDR, rand_field_number(), body_len, 8'($urandom));
        foreach (elems[e]) send_item(REQ_BARE, 29'($urandom), elems[e], 8'($urandom));
      end else begin
        send_item(REQ_LEN_HDR, rand_field_number(), 64'(n_elems), 8'($urandom));
        for (int e = 0; e < n_elems; e++)
          send_item(REQ_RAW, 29'($urandom), {$urandom, $urandom}, 8'($urandom));
      end
    end
    wait_for_drain();
  endtask

  task automatic test_random_items();
    req_type_t kind;
    for (int i = 0; i < 60; i++) begin
      // a stretch with both channels running flat out
      gaps_on   = !(i >= 20 && i < 50);
      stalls_on = gaps_on;
      kind = req_type_t'($urandom_range(3));
      send_item(kind, rand_field_number(), rand_varint_value(), 8'($urandom));
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_output_hold_off();
    req_type_t kind;
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      kind = ($urandom_range(1) != 0) ? REQ_RAW : REQ_VARINT;
      send_item(kind, rand_field_number(), rand_varint_value(), 8'($urandom));
    end
    wait_for_drain();
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_VARINT;
    in_ch.field_number = '0;
    in_ch.value        = '0;
    in_ch.payload_byte = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_corner_values();
    test_length_bodies();
    test_random_items();
    test_output_hold_off();

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && wire_bytes_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
